@@ sv/b64d_pkg.sv @@
// Shared types, codes and constants for the base64 decoder.
package b64d_pkg;

  // Default depth of the queue between the front and back parts
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_OK   = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  // One input transaction
  typedef struct packed {
    logic [7:0] char_code;
    logic       final_char;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       run_end;
  } out_item_t;

  // Work for the back part: decoded bytes of one group and/or a status
  typedef struct packed {
    logic [1:0]      byte_count;    // 0..3 bytes, in order data[0], data[1], ...
    logic [2:0][7:0] data;
    logic            status_valid;  // a status result follows the bytes
    logic            status_bad;
  } group_cmd_t;

endpackage

@@ sv/b64d_front.sv @@
// Front part: takes characters, tracks group state, emits group commands.
module b64d_front import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  in_item_t   in_item,
  output logic       cmd_valid,
  output group_cmd_t cmd
);

  logic [1:0]  group_position, group_position_next;
  logic [17:0] sextet_store, sextet_store_next;
  logic        third_was_pad, third_was_pad_next;
  logic        message_bad, message_bad_next;
  logic        saw_padded_group, saw_padded_group_next;

  logic       is_pad;
  logic       in_alpha;
  logic [5:0] sextet;
  logic [5:0] sa, sb, sc, sd;

  // Map an ASCII code to its sextet; flag codes outside the alphabet
  always_comb begin
    in_alpha = 1'b1;
    sextet   = 6'd0;
    if (in_item.char_code inside {[8'h41:8'h5A]}) begin
      sextet = 6'(in_item.char_code - 8'h41);
    end else if (in_item.char_code inside {[8'h61:8'h7A]}) begin
      sextet = 6'(in_item.char_code - 8'h61 + 8'd26);
    end else if (in_item.char_code inside {[8'h30:8'h39]}) begin
      sextet = 6'(in_item.char_code - 8'h30 + 8'd52);
    end else if (in_item.char_code == 8'h2B) begin
      sextet = 6'd62;
    end else if (in_item.char_code == 8'h2F) begin
      sextet = 6'd63;
    end else begin
      in_alpha = 1'b0;
    end
  end

  assign is_pad = (in_item.char_code == PAD_CHAR);
  assign sa = sextet_store[17:12];
  assign sb = sextet_store[11:6];
  assign sc = sextet_store[5:0];
  assign sd = is_pad ? 6'd0 : sextet;

  // Step the group state and build the command for this character
  always_comb begin
    group_position_next   = group_position;
    sextet_store_next     = sextet_store;
    third_was_pad_next    = third_was_pad;
    message_bad_next      = message_bad;
    saw_padded_group_next = saw_padded_group;
    cmd.byte_count   = 2'd0;
    cmd.data[0]      = {sa, sb[5:4]};
    cmd.data[1]      = {sb[3:0], sc[5:2]};
    cmd.data[2]      = {sc[1:0], sd};
    cmd.status_valid = 1'b0;
    cmd.status_bad   = 1'b0;

    if (!message_bad) begin
      if (saw_padded_group) begin
        message_bad_next = 1'b1;
      end else if (group_position < 2'd2) begin
        if (!in_alpha) begin
          message_bad_next = 1'b1;
        end else begin
          sextet_store_next   = {sextet_store[11:0], sextet};
          group_position_next = group_position + 2'd1;
        end
      end else if (group_position == 2'd2) begin
        if (is_pad) begin
          third_was_pad_next  = 1'b1;
          sextet_store_next   = {sextet_store[11:0], 6'd0};
          group_position_next = 2'd3;
        end else if (!in_alpha) begin
          message_bad_next = 1'b1;
        end else begin
          sextet_store_next   = {sextet_store[11:0], sextet};
          group_position_next = 2'd3;
        end
      end else begin
        if (!is_pad && (third_was_pad || !in_alpha)) begin
          message_bad_next = 1'b1;
        end else begin
          // Padding in place three implies padding in place four here
          cmd.byte_count = 2'd1 + {1'b0, !third_was_pad} + {1'b0, !is_pad};
          if (is_pad) begin
            saw_padded_group_next = 1'b1;
          end
          third_was_pad_next  = 1'b0;
          sextet_store_next   = 18'd0;
          group_position_next = 2'd0;
        end
      end
    end

    // Close the message on its final character
    if (in_item.final_char) begin
      cmd.status_valid = 1'b1;
      cmd.status_bad   = message_bad_next || (group_position_next != 2'd0);
      group_position_next   = 2'd0;
      sextet_store_next     = 18'd0;
      third_was_pad_next    = 1'b0;
      message_bad_next      = 1'b0;
      saw_padded_group_next = 1'b0;
    end
  end

  assign cmd_valid = accept && (cmd.status_valid || (cmd.byte_count != 2'd0));

  // Hold state between characters; advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      group_position   <= 2'd0;
      sextet_store     <= 18'd0;
      third_was_pad    <= 1'b0;
      message_bad      <= 1'b0;
      saw_padded_group <= 1'b0;
    end else if (accept) begin
      group_position   <= group_position_next;
      sextet_store     <= sextet_store_next;
      third_was_pad    <= third_was_pad_next;
      message_bad      <= message_bad_next;
      saw_padded_group <= saw_padded_group_next;
    end
  end

endmodule

@@ sv/b64d_queue.sv @@
// Short queue of group commands between the front and back parts.
module b64d_queue import b64d_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  group_cmd_t wr_data,
  output logic       full,
  input  logic       rd_en,
  output group_cmd_t rd_data,
  output logic       rd_valid
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  group_cmd_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];

  // Store an entry on write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/b64d_back.sv @@
// Back part: expands the head group command into result transactions.
module b64d_back import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  group_cmd_t cmd,
  input  logic       cmd_valid,
  output logic       cmd_done,
  output logic       empty,
  input  logic       pop,
  output out_item_t  out_item
);

  logic [1:0] idx;
  logic       is_byte;
  logic       is_last;

  assign empty   = !cmd_valid;
  assign is_byte = (idx < cmd.byte_count);
  assign is_last = is_byte ? ((idx == cmd.byte_count - 2'd1) && !cmd.status_valid) : 1'b1;

  // Select the current result of the head command
  always_comb begin
    out_item.run_end = is_last;
    if (is_byte) begin
      out_item.kind      = KIND_BYTE;
      out_item.data_byte = cmd.data[idx];
    end else begin
      out_item.kind      = cmd.status_bad ? KIND_BAD : KIND_OK;
      out_item.data_byte = 8'd0;
    end
  end

  assign cmd_done = pop && cmd_valid && is_last;

  // Advance through the results; drop the command after its last one
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (pop && cmd_valid) begin
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

@@ sv/base64_decoder.sv @@
// Top level of the streaming base64 decoder.
//
//   channel   handshake          payload
//   input     push / full        in_item  (char_code, final_char)
//   result    empty / pop        out_item (kind, data_byte, run_end)
//
// One character is taken per cycle while the command queue has room; the front
// part decodes it in the same cycle. Each character gives zero to four results,
// delivered one per cycle while pop is high, by the back part from the queue head.
// full rises only when QUEUE_DEPTH commands wait on the result side.
// Reset (synchronous) empties the queue and clears the group state.
module base64_decoder import b64d_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic       accept;
  logic       wr_en;
  group_cmd_t wr_cmd;
  group_cmd_t head_cmd;
  logic       head_valid;
  logic       head_done;

  assign accept = push && !full;

  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_item   (in_item),
    .cmd_valid (wr_en),
    .cmd       (wr_cmd)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_data  (wr_cmd),
    .full     (full),
    .rd_en    (head_done),
    .rd_data  (head_cmd),
    .rd_valid (head_valid)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head_cmd),
    .cmd_valid (head_valid),
    .cmd_done  (head_done),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

@@ tb/base64_decoder_checker.sv @@
// Checker for the base64 decoder: predicts decoded bytes and status, compares results.
module base64_decoder_checker import b64d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  in_item_t  in_item,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [6:0] NOT_SEXTET = 7'd64;

  // Predicted decoder state
  logic [1:0]  group_pos;
  logic [17:0] sextets;
  logic        third_pad;
  logic        msg_bad;
  logic        padded_seen;

  // Decoded bytes and status results not yet seen on the output
  out_item_t decoded_q[$];

  // Map an ASCII code to its sextet, or NOT_SEXTET outside the alphabet
  function automatic logic [6:0] sextet_value(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);        // A..Z
    if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26); // a..z
    if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52); // 0..9
    if (c == 8'h2B) return 7'd62;                               // +
    if (c == 8'h2F) return 7'd63;                               // /
    return NOT_SEXTET;
  endfunction

  task automatic add_result(input kind_t kind, input logic [7:0] data);
    out_item_t r;
    r.kind      = kind;
    r.data_byte = data;
    r.run_end   = 1'b0;
    decoded_q   = {decoded_q, r};
  endtask

  task automatic clear_group_state();
    group_pos   = 2'd0;
    sextets     = '0;
    third_pad   = 1'b0;
    msg_bad     = 1'b0;
    padded_seen = 1'b0;
  endtask

  // Advance the predicted state by one character and queue its results
  task automatic decode_char(input in_item_t it);
    logic [6:0] v;
    logic       is_pad;
    logic [5:0] a, b, s3, d;
    int         first;
    out_item_t  last_r;
    first  = decoded_q.size();
    v      = sextet_value(it.char_code);
    is_pad = (it.char_code == PAD_CHAR);
    if (!msg_bad) begin
      if (padded_seen) begin
        msg_bad = 1'b1;
      end else if (group_pos < 2'd2) begin
        if (v[6]) begin
          msg_bad = 1'b1;
        end else begin
          sextets   = {sextets[11:0], v[5:0]};
          group_pos = group_pos + 2'd1;
        end
      end else if (group_pos == 2'd2) begin
        if (is_pad) begin
          third_pad = 1'b1;
          sextets   = {sextets[11:0], 6'd0};
          group_pos = 2'd3;
        end else if (v[6]) begin
          msg_bad = 1'b1;
        end else begin
          sextets   = {sextets[11:0], v[5:0]};
          group_pos = 2'd3;
        end
      end else begin
        if (!is_pad && (third_pad || v[6])) begin
          msg_bad = 1'b1;
        end else begin
          // Close the group: one to three bytes depending on padding
          a  = sextets[17:12];
          b  = sextets[11:6];
          s3 = sextets[5:0];
          d  = is_pad ? 6'd0 : v[5:0];
          add_result(KIND_BYTE, {a, b[5:4]});
          if (!third_pad) add_result(KIND_BYTE, {b[3:0], s3[5:2]});
          if (!is_pad) add_result(KIND_BYTE, {s3[1:0], d});
          if (is_pad) padded_seen = 1'b1;
          third_pad = 1'b0;
          sextets   = '0;
          group_pos = 2'd0;
        end
      end
    end
    // Final character: an open group makes the message malformed
    if (it.final_char) begin
      if (!msg_bad && group_pos != 2'd0) msg_bad = 1'b1;
      add_result(msg_bad ? KIND_BAD : KIND_OK, 8'h00);
      clear_group_state();
    end
    // Mark the last result of this transaction
    if (decoded_q.size() > first) begin
      last_r = decoded_q[decoded_q.size() - 1];
      last_r.run_end = 1'b1;
      decoded_q[decoded_q.size() - 1] = last_r;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Predict on input transactions, compare on result transactions
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst) begin
      clear_group_state();
      decoded_q.delete();
      fail_count = 0;
    end else begin
      if (push && !full) decode_char(in_item);
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h run_end %0b",
                                    out_item.kind, out_item.data_byte, out_item.run_end));
        end else begin
          exp_r = decoded_q.pop_front();
          if (out_item.kind !== exp_r.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_item.kind, exp_r.kind));
          if (out_item.data_byte !== exp_r.data_byte)
            report_mismatch($sformatf("data_byte %02h, expected %02h",
                                      out_item.data_byte, exp_r.data_byte));
          if (out_item.run_end !== exp_r.run_end)
            report_mismatch($sformatf("run_end %0b, expected %0b",
                                      out_item.run_end, exp_r.run_end));
        end
      end
    end
    pending_count = decoded_q.size();
  end

endmodule

@@ tb/base64_decoder_test.sv @@
// Testbench top for the base64 decoder: clock, reset, stimulus, receiver and verdict.
module base64_decoder_test;
  import b64d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 4;
  localparam int RESET_CYCLES    = 8;
  localparam int RANDOM_CHARS    = 300;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES    = 16;
  localparam int MAX_GAP         = 6;

  logic      clk = 1'b0;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  int fail_count;
  int pending_count;
  int chars_sent;

  bit sender_gaps_on;
  bit receiver_gaps_on;
  bit hold_off_request;

  logic [7:0] msg_chars[$];

  base64_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  base64_decoder_checker chk (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .in_item       (in_item),
    .empty         (empty),
    .pop           (pop),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Map a sextet to its character in the standard alphabet
  function automatic logic [7:0] char_of(input logic [5:0] s);
    if (s < 6'd26) return 8'h41 + 8'(s);
    if (s < 6'd52) return 8'h61 + 8'(s - 6'd26);
    if (s < 6'd62) return 8'h30 + 8'(s - 6'd52);
    if (s == 6'd62) return 8'h2B;
    return 8'h2F;
  endfunction

  // Offer one character after a random gap and hold it until accepted
  task automatic send_char(input logic [7:0] code, input logic last);
    int gap;
    gap = sender_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push    <= 1'b1;
    in_item <= '{char_code: code, final_char: last};
    do @(posedge clk); while (full);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_buffer();
    for (int i = 0; i < msg_chars.size(); i++) send_char(msg_chars[i], i == msg_chars.size() - 1);
  endtask

  // Add one character at the end of the message buffer
  task automatic append_char(input logic [7:0] c);
    msg_chars = {msg_chars, c};
  endtask

  // Fill the buffer with a well-formed encoding of random bytes
  task automatic build_encoded(input int nbytes);
    logic [23:0] bits;
    int          remaining;
    msg_chars.delete();
    for (int i = 0; i < nbytes; i += 3) begin
      remaining = nbytes - i;
      bits = 24'($urandom());
      append_char(char_of(bits[23:18]));
      append_char(char_of(bits[17:12]));
      append_char(remaining >= 2 ? char_of(bits[11:6]) : PAD_CHAR);
      append_char(remaining >= 3 ? char_of(bits[5:0]) : PAD_CHAR);
    end
  endtask

  // Stop offering and wait until every expected result has come
  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    wait (pending_count == 0);
  endtask

  // Reset once, then the stimulus
  initial begin
    int  r;
    int  idx;
    int  random_start;
    bit  hold_done;
    bit  pause_done;
    rst              = 1'b1;
    push             = 1'b0;
    in_item          = '0;
    sender_gaps_on   = 1'b1;
    receiver_gaps_on = 1'b1;
    hold_off_request = 1'b0;
    chars_sent       = 0;
    hold_done        = 1'b0;
    pause_done       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: alphabet extremes, both pad forms, pad bits, each kind of error
    send_text("/+z0TWE=");
    send_text("TR==A");
    send_text("=");
    send_text("A=");
    send_text("AB=C");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_text("TWF");
    drain_results();

    // Random: mostly well-formed messages, some broken ones and noise
    random_start = chars_sent;
    while (chars_sent - random_start < RANDOM_CHARS) begin
      if ($urandom_range(0, 7) == 0) sender_gaps_on = ~sender_gaps_on;
      if ($urandom_range(0, 7) == 0) receiver_gaps_on = ~receiver_gaps_on;
      r = $urandom_range(0, 9);
      if (r < 7) begin
        build_encoded($urandom_range(1, 9));
      end else if (r == 7) begin
        // corrupt one place with padding or any code
        build_encoded($urandom_range(1, 9));
        idx = $urandom_range(0, msg_chars.size() - 1);
        msg_chars[idx] = $urandom_range(0, 1) ? PAD_CHAR : 8'($urandom_range(0, 255));
      end else if (r == 8) begin
        // cut short, or run on past the end
        build_encoded($urandom_range(1, 9));
        if ($urandom_range(0, 1)) begin
          repeat ($urandom_range(1, 3)) msg_chars.pop_back();
        end else begin
          repeat ($urandom_range(1, 4)) append_char(char_of(6'($urandom())));
        end
      end else begin
        msg_chars.delete();
        repeat ($urandom_range(1, 6)) append_char(8'($urandom_range(0, 255)));
      end
      send_buffer();

      // Stall the receiver once while characters keep coming
      if (!hold_done && chars_sent - random_start >= 100) begin
        hold_done        = 1'b1;
        hold_off_request = 1'b1;
      end
      // Pause the sender once until the output side is empty
      if (!pause_done && chars_sent - random_start >= 200) begin
        pause_done = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver: random gaps between pops, one long hold-off on request
  initial begin
    int gap;
    pop = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        @(negedge clk);
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end
      gap = receiver_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        @(negedge clk);
        pop <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Timeout
  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_decoder.sv
tb/base64_decoder_checker.sv
tb/base64_decoder_test.sv
